// ===== rtl/lmfs_pkg.sv =====
// Shared constants, types and pixel mapping for the LED matrix frame shifter.
package lmfs_pkg;

    localparam int MODULES   = 5;
    localparam int WORDS     = 24;
    localparam int WORD_BITS = 32;
    localparam int ROW_W     = WORD_BITS * MODULES;   // one frame word across all modules
    localparam int WORD_W    = 5;                     // word index within a bank
    localparam int ADDR_W    = WORD_W + 1;            // bank bit on top of the word index
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int BITPOS_W  = 6;                     // bit within word, 0 to 32
    localparam int DOUT_W    = 5;
    localparam int DPAD_W    = (MODULES > DOUT_W) ? MODULES : DOUT_W;

    localparam logic [WORD_W-1:0]   LAST_WORD = WORD_W'(WORDS - 1);
    localparam logic [BITPOS_W-1:0] LAST_BIT  = BITPOS_W'(WORD_BITS);
    localparam logic [4:0]          LAST_ROW  = 5'd23;
    localparam logic [9:0]          X_LIMIT   = 10'(32 * MODULES);

    typedef enum logic [2:0] {
        K_TICK  = 3'd0,
        K_PIXEL = 3'd1,
        K_CLEAR = 3'd2,
        K_SWAP  = 3'd3,
        K_START = 3'd4
    } t_kind;

    // Bit number within a word for a pixel, before the final 31-n flip.
    function automatic logic [4:0] bit_map(input logic [2:0] row, input logic [1:0] col);
        logic [4:0] v;
        case ({row, col})
            5'd0:  v = 5'd25;  5'd1:  v = 5'd30;  5'd2:  v = 5'd6;   5'd3:  v = 5'd5;
            5'd4:  v = 5'd29;  5'd5:  v = 5'd31;  5'd6:  v = 5'd2;   5'd7:  v = 5'd1;
            5'd8:  v = 5'd27;  5'd9:  v = 5'd28;  5'd10: v = 5'd0;   5'd11: v = 5'd3;
            5'd12: v = 5'd24;  5'd13: v = 5'd26;  5'd14: v = 5'd4;   5'd15: v = 5'd7;
            5'd16: v = 5'd23;  5'd17: v = 5'd22;  5'd18: v = 5'd8;   5'd19: v = 5'd9;
            5'd20: v = 5'd21;  5'd21: v = 5'd19;  5'd22: v = 5'd11;  5'd23: v = 5'd10;
            5'd24: v = 5'd18;  5'd25: v = 5'd17;  5'd26: v = 5'd14;  5'd27: v = 5'd12;
            5'd28: v = 5'd16;  5'd29: v = 5'd20;  5'd30: v = 5'd13;  5'd31: v = 5'd15;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/lmfs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lmfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/led_matrix_frame_shifter_core.sv =====
// Top level of the double-buffered LED matrix frame shifter.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  command | in  | start & !busy      | i_kind, i_pixel_x, i_pixel_y, i_pixel_on
//  result  | out | o_strobe, 1 cycle  | o_clock_line, o_load_line, o_data_lines, o_sending
//
// Each frame word row (all modules side by side) is one RAM entry, bank bit on top.
// Tick completes at the accept, or goes through a RAM read when a falling tick fetches data
// bits; set pixel reads the RAM, then modifies and writes back (done at the accept when off
// the display); clear back bank is the accept, then one word row per cycle; swap, start and
// unused codes complete at the accept. Busy stays low while a result is on the strobe.
// Synchronous reset; per-row valid bits make the whole store read as zero after it.
// The receiver cannot stall: each result shows for exactly one cycle.
module led_matrix_frame_shifter_core
    import lmfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_kind,
    input  logic [7:0]        i_pixel_x,
    input  logic [4:0]        i_pixel_y,
    input  logic              i_pixel_on,
    output logic              o_strobe,
    output logic              o_clock_line,
    output logic              o_load_line,
    output logic [DOUT_W-1:0] o_data_lines,
    output logic              o_sending
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PIX,
        S_TICK,
        S_CLR
    } t_state;

    t_state                r_state;
    logic                  r_strobe;
    logic                  r_front;
    logic                  r_send;
    logic [BITPOS_W-1:0]   r_bit;
    logic [WORD_W-1:0]     r_word;
    logic                  r_rising;
    logic                  r_clk;
    logic                  r_load;
    logic [DPAD_W-1:0]     r_data;
    logic [RAM_DEPTH-1:0]  r_valid;
    logic                  r_rd_vld;
    logic [ADDR_W-1:0]     r_addr;
    logic [8:0]            r_pos;
    logic                  r_on;
    logic [WORD_W-1:0]     r_cnt;

    logic                  accept;
    logic [4:0]            ly;
    logic [4:0]            lx;
    logic [WORD_W-1:0]     pix_word;
    logic [8:0]            pix_pos;
    logic                  pix_ok;
    logic                  tick_fetch;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ROW_W-1:0]      rd_data;
    logic [ROW_W-1:0]      row_eff;
    logic [ROW_W-1:0]      mask;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ROW_W-1:0]      wr_data;
    logic [MODULES-1:0]    fetched;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Pixel mapping: flip both axes inside a module, then look up the bit.
    assign lx       = ~i_pixel_x[4:0];
    assign ly       = LAST_ROW - i_pixel_y;
    assign pix_word = {ly[4:3], lx[4:2]};
    assign pix_pos  = {1'b0, i_pixel_x[7:5], ~bit_map(ly[2:0], lx[1:0])};
    assign pix_ok   = ({2'b00, i_pixel_x} < X_LIMIT) && (i_pixel_y <= LAST_ROW);

    assign tick_fetch = r_send && !r_rising && (r_bit != LAST_BIT);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {r_front, r_word};
        if (r_state == S_IDLE && accept) begin
            if (i_kind == K_PIXEL) begin
                rd_en   = pix_ok;
                rd_addr = {~r_front, pix_word};
            end else if (i_kind == K_TICK) begin
                rd_en   = tick_fetch;
            end
        end
    end

    lmfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Rows never written since reset read as zero.
    assign row_eff = r_rd_vld ? rd_data : '0;
    assign mask    = ROW_W'(1) << r_pos;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = r_on ? (row_eff | mask) : (row_eff & ~mask);
        if (r_state == S_PIX) begin
            wr_en = 1'b1;
        end else if (r_state == S_CLR) begin
            wr_en   = 1'b1;
            wr_addr = {~r_front, r_cnt};
            wr_data = '0;
        end
    end

    always_comb begin
        logic [WORD_BITS-1:0] mod_word;
        for (int m = 0; m < MODULES; m++) begin
            mod_word   = row_eff[m*WORD_BITS +: WORD_BITS];
            fetched[m] = mod_word[r_bit[4:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_front  <= 1'b0;
            r_send   <= 1'b1;
            r_bit    <= '0;
            r_word   <= '0;
            r_rising <= 1'b0;
            r_clk    <= 1'b0;
            r_load   <= 1'b0;
            r_data   <= '0;
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (rd_en) begin
                r_rd_vld <= r_valid[rd_addr];
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_strobe <= 1'b1;
                        case (t_kind'(i_kind))
                            K_TICK: begin
                                if (r_send) begin
                                    r_load <= 1'b0;
                                    if (r_rising) begin
                                        r_clk    <= 1'b1;
                                        r_rising <= 1'b0;
                                        if (r_bit == LAST_BIT) begin
                                            r_bit <= '0;
                                            if (r_word == LAST_WORD) begin
                                                r_word <= '0;
                                                r_load <= 1'b1;
                                                r_send <= 1'b0;
                                            end else begin
                                                r_word <= r_word + 1'b1;
                                            end
                                        end else begin
                                            r_bit <= r_bit + 1'b1;
                                        end
                                    end else begin
                                        r_clk    <= 1'b0;
                                        r_rising <= 1'b1;
                                        // fetch data bits; result follows the RAM read
                                        if (tick_fetch) begin
                                            r_strobe <= 1'b0;
                                            r_state  <= S_TICK;
                                        end
                                    end
                                end
                            end
                            K_PIXEL: begin
                                r_addr <= {~r_front, pix_word};
                                r_pos  <= pix_pos;
                                r_on   <= i_pixel_on;
                                if (pix_ok) begin
                                    r_strobe <= 1'b0;
                                    r_state  <= S_PIX;
                                end
                            end
                            K_CLEAR: begin
                                r_strobe <= 1'b0;
                                r_cnt    <= '0;
                                r_state  <= S_CLR;
                            end
                            K_SWAP:  r_front <= ~r_front;
                            K_START: r_send  <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                S_PIX: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_TICK: begin
                    r_data[MODULES-1:0] <= fetched;
                    r_strobe            <= 1'b1;
                    r_state             <= S_IDLE;
                end
                S_CLR: begin
                    if (r_cnt == LAST_WORD) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe     = r_strobe;
    assign o_clock_line = r_clk;
    assign o_load_line  = r_load;
    assign o_data_lines = r_data[DOUT_W-1:0];
    assign o_sending    = r_send;

endmodule
